@@ design/simt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted interval merge table package
// Shared constants and types for the front, queue and back of the block.
// ----------------------------------------------------------------------------
package simt_pkg;

  localparam int MaxRangesDefault = 256;
  localparam int ValueBitsDefault = 48;
  localparam int InBits           = 48;
  localparam int CountBits        = 9;
  localparam int TotalBits        = 49;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIND,
    BK_SCAN,
    BK_SHIFT,
    BK_WRITE,
    BK_SUM,
    BK_DONE
  } back_state_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic               bad;
    logic [InBits-1:0]  lo;
    logic [InBits-1:0]  hi;
  } job_t;

endpackage

@@ design/simt_front.sv @@
// ----------------------------------------------------------------------------
// Sorted interval merge table front end
// Accepts ranges, masks them to the value width, flags reversed ranges and
// pushes them into a two-entry queue towards the back end.
// ----------------------------------------------------------------------------
module simt_front #(
  parameter int VALUE_BITS = simt_pkg::ValueBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [simt_pkg::InBits-1:0]  range_low,
  input  logic [simt_pkg::InBits-1:0]  range_high,
  output logic                         job_valid,
  input  logic                         job_ready,
  output simt_pkg::job_t               job
);

  localparam logic [simt_pkg::InBits-1:0] Mask =
    simt_pkg::InBits'((65'd1 << VALUE_BITS) - 65'd1);

  simt_pkg::job_t q [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     fill;
  logic [simt_pkg::InBits-1:0] lo_m, hi_m;
  logic           push, pop;

  assign lo_m     = range_low & Mask;
  assign hi_m     = range_high & Mask;
  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign job_valid = (fill != 2'd0);
  assign pop      = job_valid && job_ready;
  assign job      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{bad: (lo_m > hi_m), lo: lo_m, hi: hi_m};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/simt_back.sv @@
// ----------------------------------------------------------------------------
// Sorted interval merge table back end
// Searches, merges or inserts into the stored tables one entry at a time,
// then sums the covered total and holds the result in an output register.
// ----------------------------------------------------------------------------
module simt_back #(
  parameter int MAX_RANGES = simt_pkg::MaxRangesDefault,
  parameter int VALUE_BITS = simt_pkg::ValueBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  simt_pkg::job_t                  job,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [simt_pkg::CountBits-1:0]  range_count,
  output logic [simt_pkg::TotalBits-1:0]  covered_total
);

  localparam int AW = $clog2(MAX_RANGES);
  localparam int NW = $clog2(MAX_RANGES + 1);
  localparam int VW = VALUE_BITS + 1;
  localparam logic [NW-1:0] MaxN = NW'(MAX_RANGES);

  simt_pkg::back_state_t state, state_next;

  logic [VALUE_BITS-1:0] mem_lo [MAX_RANGES];
  logic [VALUE_BITS-1:0] mem_hi [MAX_RANGES];
  logic [VALUE_BITS-1:0] rd_lo, rd_hi;

  logic [NW-1:0] n, idx, first, last;
  logic [VALUE_BITS-1:0] lo, hi, new_lo, new_hi;
  logic [simt_pkg::TotalBits-1:0] total;
  simt_pkg::status_t st;
  logic          rd_pend, rd_pend_next;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [VALUE_BITS-1:0] wr_lo, wr_hi;

  logic          sh_v, sh_v_next;
  logic [AW-1:0] sh_dst;
  logic [NW-1:0] sh_cnt;
  logic [NW-1:0] drop, src, dst;

  logic [VW-1:0] rhi_p1, hi_p1;
  logic gap, found_first, found_last, sh_done, out_free;

  // Read data arrives in the cycle after the address; rd_pend marks it valid.
  always_ff @(posedge clk) begin
    rd_lo <= mem_lo[rd_addr];
    rd_hi <= mem_hi[rd_addr];
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_lo;
      mem_hi[wr_addr] <= wr_hi;
    end
  end

  assign rhi_p1      = {1'b0, rd_hi} + VW'(1);
  assign hi_p1       = {1'b0, hi} + VW'(1);
  assign gap         = (first == last);
  assign found_first = (idx == n) || (rd_pend && ({1'b0, lo} <= rhi_p1));
  assign found_last  = (idx == n) || (rd_pend && (hi_p1 < {1'b0, rd_lo}));
  assign sh_done     = (idx == sh_cnt);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      simt_pkg::BK_IDLE:  if (job_valid) state_next = job.bad ? simt_pkg::BK_DONE
                                                                : simt_pkg::BK_FIND;
      simt_pkg::BK_FIND:  if (found_first) state_next = simt_pkg::BK_SCAN;
      simt_pkg::BK_SCAN: begin
        if (found_last) begin
          if (first == idx && n == MaxN) state_next = simt_pkg::BK_DONE;
          else state_next = simt_pkg::BK_SHIFT;
        end
      end
      simt_pkg::BK_SHIFT: if (sh_done && !sh_v) state_next = simt_pkg::BK_WRITE;
      simt_pkg::BK_WRITE: state_next = simt_pkg::BK_SUM;
      simt_pkg::BK_SUM:   if (idx == n) state_next = simt_pkg::BK_DONE;
      simt_pkg::BK_DONE:  if (out_free) state_next = simt_pkg::BK_IDLE;
      default:            state_next = simt_pkg::BK_IDLE;
    endcase
  end

  assign job_ready = (state == simt_pkg::BK_IDLE);

  // Shift pass: for insert, walk downward moving entry i-1 to i; for merge,
  // walk upward moving entry i+drop to i. idx counts steps done.
  always_comb begin
    drop = last - first - NW'(1);
    if (gap) begin
      dst = n - idx;
      src = dst - NW'(1);
    end else begin
      dst = first + NW'(1) + idx;
      src = dst + drop;
    end
    if (gap) sh_cnt = n - first;
    else     sh_cnt = n - last;
    unique case (state)
      simt_pkg::BK_FIND, simt_pkg::BK_SCAN, simt_pkg::BK_SUM:
        rd_addr = AW'(idx);
      simt_pkg::BK_SHIFT: rd_addr = AW'(src);
      default: rd_addr = '0;
    endcase
    // Shift writes use the registered read data; the final write places the
    // new or merged range at the first entry.
    wr_en   = sh_v || (state == simt_pkg::BK_WRITE);
    wr_addr = sh_v ? sh_dst : AW'(first);
    wr_lo   = sh_v ? rd_lo : new_lo;
    wr_hi   = sh_v ? rd_hi : new_hi;
  end

  always_comb begin
    rd_pend_next = 1'b0;
    sh_v_next    = 1'b0;
    unique case (state)
      simt_pkg::BK_FIND:  rd_pend_next = !found_first && !rd_pend;
      simt_pkg::BK_SCAN:  rd_pend_next = !found_last && !rd_pend;
      simt_pkg::BK_SUM:   rd_pend_next = (idx != n) && !rd_pend;
      simt_pkg::BK_SHIFT: sh_v_next    = !sh_done && !sh_v;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      sh_v    <= 1'b0;
    end else begin
      rd_pend <= rd_pend_next;
      sh_v    <= sh_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == simt_pkg::BK_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= simt_pkg::BK_IDLE;
      n     <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        simt_pkg::BK_IDLE: begin
          lo  <= VALUE_BITS'(job.lo);
          hi  <= VALUE_BITS'(job.hi);
          idx <= '0;
          st  <= simt_pkg::ST_REJECTED;
        end
        simt_pkg::BK_FIND: begin
          if (found_first) begin
            first  <= idx;
            new_lo <= (rd_pend && idx != n && rd_lo < lo) ? rd_lo : lo;
            new_hi <= hi;
          end else if (rd_pend) begin
            idx <= idx + NW'(1);
          end
        end
        simt_pkg::BK_SCAN: begin
          if (found_last) begin
            last <= idx;
            st <= (first == idx) ? ((n == MaxN) ? simt_pkg::ST_FULL : simt_pkg::ST_INSERTED)
                                 : simt_pkg::ST_MERGED;
            idx <= '0;
          end else if (rd_pend) begin
            if (rd_hi > new_hi) new_hi <= rd_hi;
            if (idx == first && rd_lo < new_lo) new_lo <= rd_lo;
            idx <= idx + NW'(1);
          end
        end
        simt_pkg::BK_SHIFT: begin
          // each entry is read, then written
          if (sh_v) begin
            idx <= idx + NW'(1);
          end else if (sh_done) begin
            idx <= '0;
            n   <= gap ? n + NW'(1) : n - drop;
          end else begin
            sh_dst <= AW'(dst);
          end
        end
        simt_pkg::BK_WRITE: begin
          idx   <= '0;
          total <= '0;
        end
        simt_pkg::BK_SUM: begin
          if (idx != n && rd_pend) begin
            total <= total + simt_pkg::TotalBits'({1'b0, rd_hi} - {1'b0, rd_lo} + VW'(1));
            idx   <= idx + NW'(1);
          end
        end
        simt_pkg::BK_DONE: begin
          if (out_free) begin
            status        <= st;
            range_count   <= simt_pkg::CountBits'(n);
            covered_total <= total;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/sorted_interval_merge_table.sv @@
// ----------------------------------------------------------------------------
// Sorted interval merge table
// Keeps a sorted table of disjoint inclusive ranges and merges new ones.
// ----------------------------------------------------------------------------
// Usage: each input word (range_low, range_high) is taken on in_valid and
// in_ready. Exactly one result word (status, range_count, covered_total)
// follows on out_valid and out_ready, in input order.
// A front end checks and queues up to two words, so the sender can keep
// pushing while the back end works. The back end walks the table one entry
// at a time in a search pass, a shift pass and a summing pass. It skips
// all passes for a rejected word, and the last two for an insert into a
// full table. A stalled receiver holds the result register; the back end
// then waits and the queue fills before in_ready falls.
// Reset empties the table and the queue; table contents are not cleared,
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_interval_merge_table #(
  parameter int MAX_RANGES = simt_pkg::MaxRangesDefault,
  parameter int VALUE_BITS = simt_pkg::ValueBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [simt_pkg::InBits-1:0]     range_low,
  input  logic [simt_pkg::InBits-1:0]     range_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [simt_pkg::CountBits-1:0]  range_count,
  output logic [simt_pkg::TotalBits-1:0]  covered_total
);

  logic           job_valid, job_ready;
  simt_pkg::job_t job;

  simt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .range_low, .range_high,
    .job_valid, .job_ready, .job
  );

  simt_back #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .status, .range_count, .covered_total
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (range_count <= simt_pkg::CountBits'(MAX_RANGES)))
    else $error("range count above table size");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == simt_pkg::ST_FULL) |->
      (range_count == simt_pkg::CountBits'(MAX_RANGES)))
    else $error("full refusal with table not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(covered_total)))
    else $error("result changed while stalled");

endmodule
